### rtl/cfa_pkg.sv
// Package with the opcodes, widths and pipeline types of the constant-folding ALU.
package cfa_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int IO_WIDTH   = 64;
  localparam int HALF_W     = DATA_WIDTH / 2;
  localparam int SH_W       = $clog2(DATA_WIDTH);

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,  OP_SUB = 5'd1,  OP_MUL = 5'd2,  OP_DIV = 5'd3,
    OP_MOD = 5'd4,  OP_AND = 5'd5,  OP_OR  = 5'd6,  OP_XOR = 5'd7,
    OP_SHL = 5'd8,  OP_SHR = 5'd9,  OP_EQ  = 5'd10, OP_NE  = 5'd11,
    OP_LT  = 5'd12, OP_LE  = 5'd13, OP_GT  = 5'd14, OP_GE  = 5'd15,
    OP_NEG = 5'd16, OP_NOT = 5'd17
  } cfa_op_t;

  typedef struct packed {
    logic [4:0]            op;
    logic                  ok;
    logic [DATA_WIDTH-1:0] res;
    logic                  neg_q;
    logic                  neg_r;
    logic [DATA_WIDTH-1:0] ub;
  } cfa_ctl_t;

endpackage

### rtl/cfa_if.sv
// Valid/ready channel interfaces for the instruction input and the folded result.
interface cfa_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic        first_is_const;
  logic        second_is_const;
  logic [63:0] first_value;
  logic [63:0] second_value;

  modport source (output valid, cmd, first_is_const, second_is_const, first_value,
                  second_value, input ready);
  modport sink (input valid, cmd, first_is_const, second_is_const, first_value,
                second_value, output ready);
endinterface

interface cfa_out_if;
  logic        valid;
  logic        ready;
  logic        folded;
  logic [63:0] fold_value;

  modport source (output valid, folded, fold_value, input ready);
  modport sink (input valid, folded, fold_value, output ready);
endinterface

### rtl/constant_fold_alu.sv
// Pipelined constant-folding integer ALU with a bit-per-stage restoring divider.
// Stages in order: A (input), B, C, the divider stages, then the result register.
// Throughput: one instruction per cycle; the whole pipe holds when the result
// register is full and not taken, and moves on otherwise.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module constant_fold_alu (
  input logic clk,
  input logic rst_n,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch
);
  import cfa_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int H  = HALF_W;

  logic en;

  // Stage A: input register.
  logic          a_valid_r;
  logic [4:0]    a_cmd_r;
  logic          a_c1_r, a_c2_r;
  logic [DW-1:0] a_a_r, a_b_r;

  // Stage B: simple ops, partial products, magnitudes.
  logic          b_valid_r;
  cfa_ctl_t      b_ctl_r, b_ctl_nxt;
  logic [DW-1:0] b_p0_r, b_p1_r, b_p2_r, b_ua_r;
  logic [DW-1:0] b_p0_nxt, b_p1_nxt, b_p2_nxt, b_ua_nxt;

  // Stage C: product assembled.
  logic          c_valid_r;
  cfa_ctl_t      c_ctl_r, c_ctl_nxt;
  logic [DW-1:0] c_ua_r;

  // Divider stages.
  logic          d_valid_r [DW];
  cfa_ctl_t      d_ctl_r   [DW];
  logic [DW-1:0] d_rem_r   [DW];
  logic [DW-1:0] d_quo_r   [DW];

  logic          out_valid_r;
  logic          out_folded_r, out_folded_nxt;
  logic [63:0]   out_value_r, out_value_nxt;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_ch.valid;
    end
    if (en) begin
      a_cmd_r <= in_ch.cmd;
      a_c1_r  <= in_ch.first_is_const;
      a_c2_r  <= in_ch.second_is_const;
      a_a_r   <= in_ch.first_value[DW-1:0];
      a_b_r   <= in_ch.second_value[DW-1:0];
    end
  end

  always_comb begin
    logic both;
    logic sh_ok;
    both  = a_c1_r && a_c2_r;
    // Shift amount must be non-negative and below the word width.
    sh_ok = !a_b_r[DW-1] && (a_b_r < DW'(DW));
    b_ctl_nxt       = '0;
    b_ctl_nxt.op    = a_cmd_r;
    b_ctl_nxt.neg_q = a_a_r[DW-1] ^ a_b_r[DW-1];
    b_ctl_nxt.neg_r = a_a_r[DW-1];
    b_ctl_nxt.ub    = a_b_r[DW-1] ? (DW'(0) - a_b_r) : a_b_r;
    case (a_cmd_r)
      OP_ADD: begin b_ctl_nxt.ok = both; b_ctl_nxt.res = a_a_r + a_b_r; end
      OP_SUB: begin b_ctl_nxt.ok = both; b_ctl_nxt.res = a_a_r - a_b_r; end
      OP_MUL: b_ctl_nxt.ok = both;
      OP_DIV, OP_MOD: b_ctl_nxt.ok = both && (a_b_r != '0);
      OP_AND: begin b_ctl_nxt.ok = both; b_ctl_nxt.res = a_a_r & a_b_r; end
      OP_OR:  begin b_ctl_nxt.ok = both; b_ctl_nxt.res = a_a_r | a_b_r; end
      OP_XOR: begin b_ctl_nxt.ok = both; b_ctl_nxt.res = a_a_r ^ a_b_r; end
      OP_SHL: begin
        b_ctl_nxt.ok  = both && sh_ok;
        b_ctl_nxt.res = a_a_r << a_b_r[SH_W-1:0];
      end
      OP_SHR: begin
        b_ctl_nxt.ok  = both && sh_ok;
        b_ctl_nxt.res = DW'($signed(a_a_r) >>> a_b_r[SH_W-1:0]);
      end
      OP_EQ: begin b_ctl_nxt.ok = both; b_ctl_nxt.res = DW'(a_a_r == a_b_r); end
      OP_NE: begin b_ctl_nxt.ok = both; b_ctl_nxt.res = DW'(a_a_r != a_b_r); end
      OP_LT: begin
        b_ctl_nxt.ok  = both;
        b_ctl_nxt.res = DW'($signed(a_a_r) < $signed(a_b_r));
      end
      OP_LE: begin
        b_ctl_nxt.ok  = both;
        b_ctl_nxt.res = DW'($signed(a_a_r) <= $signed(a_b_r));
      end
      OP_GT: begin
        b_ctl_nxt.ok  = both;
        b_ctl_nxt.res = DW'($signed(a_a_r) > $signed(a_b_r));
      end
      OP_GE: begin
        b_ctl_nxt.ok  = both;
        b_ctl_nxt.res = DW'($signed(a_a_r) >= $signed(a_b_r));
      end
      OP_NEG: begin b_ctl_nxt.ok = a_c1_r; b_ctl_nxt.res = DW'(0) - a_a_r; end
      OP_NOT: begin b_ctl_nxt.ok = a_c1_r; b_ctl_nxt.res = DW'(a_a_r == '0); end
      default: b_ctl_nxt.ok = 1'b0;
    endcase
    // The low word of the product needs only three half-width products.
    b_p0_nxt = DW'(a_a_r[H-1:0]) * DW'(a_b_r[H-1:0]);
    b_p1_nxt = DW'(a_a_r[H-1:0]) * DW'(a_b_r[DW-1:H]);
    b_p2_nxt = DW'(a_a_r[DW-1:H]) * DW'(a_b_r[H-1:0]);
    b_ua_nxt = a_a_r[DW-1] ? (DW'(0) - a_a_r) : a_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
    if (en) begin
      b_ctl_r <= b_ctl_nxt;
      b_p0_r  <= b_p0_nxt;
      b_p1_r  <= b_p1_nxt;
      b_p2_r  <= b_p2_nxt;
      b_ua_r  <= b_ua_nxt;
      c_ctl_r <= c_ctl_nxt;
      c_ua_r  <= b_ua_r;
    end
  end

  always_comb begin
    c_ctl_nxt = b_ctl_r;
    if (b_ctl_r.op == OP_MUL) begin
      c_ctl_nxt.res = b_p0_r + ((b_p1_r + b_p2_r) << H);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < DW; i++) begin : g_div
    logic          vin;
    cfa_ctl_t      cin;
    logic [DW-1:0] rin, qin;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign vin = c_valid_r;
      assign cin = c_ctl_r;
      assign rin = '0;
      assign qin = c_ua_r;
    end else begin : g_next
      assign vin = d_valid_r[i-1];
      assign cin = d_ctl_r[i-1];
      assign rin = d_rem_r[i-1];
      assign qin = d_quo_r[i-1];
    end

    assign trial = {rin, qin[DW-1]};
    assign diff  = trial - {1'b0, cin.ub};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_valid_r[i] <= 1'b0;
      end else if (en) begin
        d_valid_r[i] <= vin;
      end
      if (en) begin
        d_ctl_r[i] <= cin;
        if (!diff[DW]) begin
          d_rem_r[i] <= diff[DW-1:0];
          d_quo_r[i] <= {qin[DW-2:0], 1'b1};
        end else begin
          d_rem_r[i] <= trial[DW-1:0];
          d_quo_r[i] <= {qin[DW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    cfa_ctl_t      cl;
    logic [DW-1:0] res;
    cl  = d_ctl_r[DW-1];
    res = cl.res;
    case (cl.op)
      OP_DIV:  res = cl.neg_q ? (DW'(0) - d_quo_r[DW-1]) : d_quo_r[DW-1];
      OP_MOD:  res = cl.neg_r ? (DW'(0) - d_rem_r[DW-1]) : d_rem_r[DW-1];
      default: res = cl.res;
    endcase
    out_folded_nxt = cl.ok;
    out_value_nxt  = cl.ok ? IO_WIDTH'($signed(res)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid_r[DW-1];
    end
    if (en) begin
      out_folded_r <= out_folded_nxt;
      out_value_r  <= out_value_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.folded     = out_folded_r;
  assign out_ch.fold_value = out_value_r;

endmodule
